// ----- design/ptwc_pkg.sv -----
// Package: shared types and constants of the pulse train window counter.
`default_nettype none
package ptwc_pkg;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned OUT_TW   = 48;
  localparam int unsigned CFG_IW   = 2;
  localparam int unsigned CFG_DW   = 32;
  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  localparam logic [CFG_IW-1:0] CFG_PREDELAY   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_GATE       = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_LONG_DELAY = 2'd2;

  localparam logic [23:0] PREDELAY_RST   = 24'd45;
  localparam logic [23:0] GATE_RST       = 24'd640;
  localparam logic [31:0] LONG_DELAY_RST = 32'd100000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_OVF,
    ST_PUSH,
    ST_FINAL
  } ptwc_state_t;

  // running flags of one pass over the store
  typedef struct packed {
    logic still_emit;
    logic still_drop;
  } ptwc_scan_t;

  // decision of the head unit for the entry at the front
  typedef struct packed {
    logic emit;
    logic keep;
  } ptwc_ctl_t;
endpackage
`default_nettype wire

// ----- design/ptwc_if.sv -----
// Interfaces: event word channel and result word channel.
`default_nettype none
interface ptwc_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] event_time;
  logic        last_event;
  modport source(output valid, event_time, last_event, input ready);
  modport sink(input valid, event_time, last_event, output ready);
endinterface

interface ptwc_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] result_time;
  logic [5:0]  ra_count;
  logic [5:0]  a_count;
  logic        window_overflow;
  logic        last_result;
  modport source(output valid, result_time, ra_count, a_count, window_overflow,
                 last_result, input ready);
  modport sink(input valid, result_time, ra_count, a_count, window_overflow,
               last_result, output ready);
endinterface
`default_nettype wire

// ----- design/ptwc_cell.sv -----
// Store cell: one event entry, shifted from its upper neighbor or loaded.
`default_nettype none
module ptwc_cell
  import ptwc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire                  clk,
  input  wire                  shift_en,
  input  wire                  load_en,
  input  wire [TIME_BITS-1:0]  nb_time,
  input  wire [CNT_W-1:0]      nb_ra,
  input  wire [CNT_W-1:0]      nb_a,
  input  wire                  nb_pend,
  input  wire [TIME_BITS-1:0]  ld_time,
  input  wire [CNT_W-1:0]      ld_ra,
  input  wire [CNT_W-1:0]      ld_a,
  input  wire                  ld_pend,
  output logic [TIME_BITS-1:0] time_q,
  output logic [CNT_W-1:0]     ra_q,
  output logic [CNT_W-1:0]     a_q,
  output logic                 pend_q
);
  logic [TIME_BITS-1:0] time_r;
  logic [CNT_W-1:0]     ra_r, a_r;
  logic                 pend_r;

  // load wins over shift
  always_ff @(posedge clk) begin
    if (load_en) begin
      time_r <= ld_time;
      ra_r   <= ld_ra;
      a_r    <= ld_a;
      pend_r <= ld_pend;
    end else if (shift_en) begin
      time_r <= nb_time;
      ra_r   <= nb_ra;
      a_r    <= nb_a;
      pend_r <= nb_pend;
    end
  end

  assign time_q = time_r;
  assign ra_q   = ra_r;
  assign a_q    = a_r;
  assign pend_q = pend_r;
endmodule
`default_nettype wire

// ----- design/ptwc_head.sv -----
// Head unit: judges the entry at the front of the store against the new event.
`default_nettype none
module ptwc_head
  import ptwc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire [TIME_BITS-1:0] cur_time,
  input  wire [23:0]          pre_ticks,
  input  wire [23:0]          gate_ticks,
  input  wire [31:0]          ld_ticks,
  input  wire                 last_mode,
  input  wire [TIME_BITS-1:0] e_time,
  input  wire [CNT_W-1:0]     e_a,
  input  wire                 e_pend,
  input  wire [CNT_W-1:0]     ra_acc,
  input  ptwc_scan_t          scan_in,
  output ptwc_scan_t          scan_out,
  output ptwc_ctl_t           ctl,
  output logic [CNT_W-1:0]    a_new,
  output logic                pend_new,
  output logic [CNT_W-1:0]    ra_new
);
  localparam int unsigned CW = ((TIME_BITS > 33) ? TIME_BITS : 33) + 1;

  logic [TIME_BITS-1:0] d;
  logic [CW-1:0]        dx, a_end, r_end, ldx, prex;
  logic                 in_a, in_ra, closed, settled;

  always_comb begin
    d      = cur_time - e_time;
    dx     = CW'(d);
    ldx    = CW'(ld_ticks);
    prex   = CW'(pre_ticks);
    a_end  = CW'(ld_ticks) + CW'(gate_ticks);
    r_end  = CW'(pre_ticks) + CW'(gate_ticks);
    in_a   = (dx >= ldx) && (dx < a_end);
    in_ra  = (dx >= prex) && (dx < r_end);
    closed = dx >= a_end;

    // count the new event into the accidentals window of a pending entry
    a_new = e_a;
    if (e_pend && in_a && (e_a != COUNT_MAX)) a_new = e_a + 1'b1;

    // emit closed entries in order; on the last event emit every pending one
    ctl.emit = e_pend && (last_mode || (scan_in.still_emit && closed));
    scan_out.still_emit = scan_in.still_emit && !(e_pend && !closed);
    pend_new = e_pend && !ctl.emit;

    // drop settled entries at the front that no later gate can reach
    settled  = !e_pend || ctl.emit;
    ctl.keep = !(!last_mode && settled && scan_in.still_drop && (dx >= r_end));
    scan_out.still_drop = scan_in.still_drop && !ctl.keep;

    // accumulate the RA count of the new event
    ra_new = ra_acc;
    if (in_ra && (ra_acc != COUNT_MAX)) ra_new = ra_acc + 1'b1;
  end
endmodule
`default_nettype wire

// ----- design/pulse_train_window_counter.sv -----
// Top level: pulse train window counter with a shifting store of event cells.
// Each accepted event word triggers one pass over the stored events: the
// front cell is judged by the head unit and written back at the tail, one
// entry per cycle while the result word register does not stall; a non-last
// event is then pushed, first dropping the front entry if the store holds
// STORE_DEPTH-1 entries. Results of closed windows leave during the pass;
// the last event flushes all open results and then its own result.
`default_nettype none
module pulse_train_window_counter
  import ptwc_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned TIME_BITS   = 48
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire [CFG_IW-1:0]   cfg_idx,
  input  wire [CFG_DW-1:0]   cfg_data,
  ptwc_in_if.sink            in_ch,
  ptwc_out_if.source         out_ch
);
  localparam int unsigned IW = $clog2(STORE_DEPTH);
  localparam int unsigned XW = TIME_BITS + OUT_TW;

  ptwc_state_t state_r, state_nxt;
  logic [23:0] pre_r, gate_r;
  logic [31:0] ld_r;
  logic [IW-1:0] len_r, len_nxt, rem_r, rem_nxt;
  logic [TIME_BITS-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic last_r, last_nxt, ovf_r, ovf_nxt;
  logic [CNT_W-1:0] ra_acc_r, ra_acc_nxt;
  ptwc_scan_t scan_r, scan_nxt, scan_h;
  ptwc_ctl_t ctl_h;

  logic [TIME_BITS-1:0] c_time [STORE_DEPTH];
  logic [CNT_W-1:0]     c_ra   [STORE_DEPTH];
  logic [CNT_W-1:0]     c_a    [STORE_DEPTH];
  logic                 c_pend [STORE_DEPTH];

  logic [CNT_W-1:0] a_h, ra_h;
  logic pend_h;
  logic shift_en, load_any;
  logic [IW-1:0] load_idx;
  logic [TIME_BITS-1:0] ld_time;
  logic [CNT_W-1:0] ld_ra, ld_a;
  logic ld_pend;

  logic out_valid_r, out_free, out_load;
  logic [TIME_BITS-1:0] o_time;
  logic [CNT_W-1:0] o_ra, o_a;
  logic o_ovf, o_last;
  logic [OUT_TW-1:0] out_time_r;
  logic [CNT_W-1:0] out_ra_r, out_a_r;
  logic out_ovf_r, out_last_r;

  logic [XW-1:0] in_ext, out_ext;
  logic [TIME_BITS-1:0] in_time;

  assign in_ext  = {{TIME_BITS{1'b0}}, in_ch.event_time};
  assign in_time = in_ext[TIME_BITS-1:0];
  assign out_ext = {{OUT_TW{1'b0}}, o_time};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r  <= PREDELAY_RST;
      gate_r <= GATE_RST;
      ld_r   <= LONG_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PREDELAY:   pre_r  <= cfg_data[23:0];
        CFG_GATE:       gate_r <= cfg_data[23:0];
        CFG_LONG_DELAY: ld_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // row of cells, each but the top one fed by its upper neighbor
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    localparam int unsigned NB = (i == STORE_DEPTH - 1) ? i : i + 1;
    ptwc_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk     (clk),
      .shift_en(shift_en),
      .load_en (load_any && (load_idx == IW'(i))),
      .nb_time (c_time[NB]),
      .nb_ra   (c_ra[NB]),
      .nb_a    (c_a[NB]),
      .nb_pend (c_pend[NB]),
      .ld_time (ld_time),
      .ld_ra   (ld_ra),
      .ld_a    (ld_a),
      .ld_pend (ld_pend),
      .time_q  (c_time[i]),
      .ra_q    (c_ra[i]),
      .a_q     (c_a[i]),
      .pend_q  (c_pend[i])
    );
  end

  ptwc_head #(.TIME_BITS(TIME_BITS)) u_head (
    .cur_time  (cur_r),
    .pre_ticks (pre_r),
    .gate_ticks(gate_r),
    .ld_ticks  (ld_r),
    .last_mode (last_r),
    .e_time    (c_time[0]),
    .e_a       (c_a[0]),
    .e_pend    (c_pend[0]),
    .ra_acc    (ra_acc_r),
    .scan_in   (scan_r),
    .scan_out  (scan_h),
    .ctl       (ctl_h),
    .a_new     (a_h),
    .pend_new  (pend_h),
    .ra_new    (ra_h)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  // sequencer: pass, overflow drop, push, final result
  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    last_nxt   = last_r;
    ovf_nxt    = ovf_r;
    ra_acc_nxt = ra_acc_r;
    scan_nxt   = scan_r;
    shift_en   = 1'b0;
    load_any   = 1'b0;
    load_idx   = len_r - 1'b1;
    ld_time    = c_time[0];
    ld_ra      = c_ra[0];
    ld_a       = a_h;
    ld_pend    = pend_h;
    out_load   = 1'b0;
    o_time     = c_time[0];
    o_ra       = c_ra[0];
    o_a        = a_h;
    o_ovf      = ovf_r;
    o_last     = 1'b0;
    in_ch.ready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cur_nxt    = (in_time < prev_r) ? prev_r : in_time;
          prev_nxt   = cur_nxt;
          last_nxt   = in_ch.last_event;
          rem_nxt    = len_r;
          ra_acc_nxt = '0;
          scan_nxt   = '{still_emit: 1'b1, still_drop: 1'b1};
          state_nxt  = ST_PASS;
        end
      end
      ST_PASS: begin
        if (rem_r == '0) begin
          if (last_r) state_nxt = ST_FINAL;
          else if (len_r >= IW'(STORE_DEPTH - 1)) state_nxt = ST_OVF;
          else state_nxt = ST_PUSH;
        end else if (!ctl_h.emit || out_free) begin
          // pop the front entry, write it back at the tail unless dropped
          shift_en   = 1'b1;
          load_any   = ctl_h.keep;
          out_load   = ctl_h.emit;
          if (!ctl_h.keep) len_nxt = len_r - 1'b1;
          rem_nxt    = rem_r - 1'b1;
          ra_acc_nxt = ra_h;
          scan_nxt   = scan_h;
        end
      end
      ST_OVF: begin
        if (!c_pend[0] || out_free) begin
          ovf_nxt   = 1'b1;
          o_a       = c_a[0];
          o_ovf     = 1'b1;
          out_load  = c_pend[0];
          shift_en  = 1'b1;
          len_nxt   = len_r - 1'b1;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        load_any  = 1'b1;
        load_idx  = len_r;
        ld_time   = cur_r;
        ld_ra     = ra_acc_r;
        ld_a      = '0;
        ld_pend   = 1'b1;
        len_nxt   = len_r + 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_FINAL: begin
        if (out_free) begin
          out_load  = 1'b1;
          o_time    = cur_r;
          o_ra      = ra_acc_r;
          o_a       = '0;
          o_last    = 1'b1;
          len_nxt   = '0;
          ovf_nxt   = 1'b0;
          prev_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      prev_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      prev_r  <= prev_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    cur_r    <= cur_nxt;
    last_r   <= last_nxt;
    ra_acc_r <= ra_acc_nxt;
    scan_r   <= scan_nxt;
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_time_r <= out_ext[OUT_TW-1:0];
      out_ra_r   <= o_ra;
      out_a_r    <= o_a;
      out_ovf_r  <= o_ovf;
      out_last_r <= o_last;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_time     = out_time_r;
  assign out_ch.ra_count        = out_ra_r;
  assign out_ch.a_count         = out_a_r;
  assign out_ch.window_overflow = out_ovf_r;
  assign out_ch.last_result     = out_last_r;

  // store never holds more than one slot short of its depth
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= IW'(STORE_DEPTH - 1))
    else $error("store occupancy beyond bound");

  // push only ever finds a free slot
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) |-> (len_r < IW'(STORE_DEPTH - 1)))
    else $error("push into a full store");

  // the final result empties the store and clears the overflow mark
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && o_last) |=> (len_r == '0 && !ovf_r && state_r == ST_IDLE))
    else $error("stream not cleared after final result");
endmodule
`default_nettype wire
